FILE: hdl/gob_pkg.sv
// Package for gradient orientation binning: widths, angle table and shared types.
package gob_pkg;

    // Field widths
    localparam int GRAD_W     = 11;
    localparam int MAG_W      = 8;
    localparam int BKT_W      = 6;
    localparam int CNT_W      = 7;
    localparam int THR_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_THRESHOLD = 2'd1;

    // Reset values
    localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = 7'd8;
    localparam logic [THR_W-1:0] MAG_THRESHOLD_RST = 9'd0;
    localparam logic [CNT_W-1:0] BUCKET_COUNT_MAX = 7'd64;

    // Angle arithmetic: angles in units of 2^-30 turn
    localparam int CORDIC_STEPS = 28;
    localparam int FRAC_SHIFT   = 30;
    localparam int CX_W         = 43;
    localparam int Z_W          = 31;
    localparam int OCT_W        = 27;
    localparam int Q_W          = 29;
    localparam int TURN_W       = 16;
    localparam int TURN_LSB     = 14;
    localparam int SECTOR_W     = 8;

    localparam logic [Z_W-1:0] ANGLE_ONE_TURN = 31'd1 << 30;
    localparam logic [Q_W-1:0] ANGLE_QUARTER  = 29'd1 << 28;
    localparam logic [Q_W-1:0] ANGLE_EIGHTH   = 29'd1 << 27;

    // atan(2^-i) in units of 2^-30 turn
    localparam logic [27:0] ATAN_LUT [0:CORDIC_STEPS-1] = '{
        28'd134217728, 28'd79233351, 28'd41864727, 28'd21251189, 28'd10666833,
        28'd5338616, 28'd2669960, 28'd1335061, 28'd667541, 28'd333772,
        28'd166886, 28'd83443, 28'd41722, 28'd20861, 28'd10430, 28'd5215,
        28'd2608, 28'd1304, 28'd652, 28'd326, 28'd163, 28'd81, 28'd41,
        28'd20, 28'd10, 28'd5, 28'd3, 28'd1
    };

    // How the angle inside the quadrant is formed
    typedef enum logic [1:0] {
        OCT_ZERO,   // on the axis
        OCT_DIAG,   // exactly on the diagonal
        OCT_LOW,    // below the diagonal: rotate (u, v)
        OCT_HIGH    // above the diagonal: rotate (v, u), mirror the result
    } t_oct_case;

endpackage

FILE: hdl/gradient_orientation_binning.sv
// Gradient orientation binning: magnitude, threshold and CORDIC angle buckets.
// A result passes stages A and B, the CORDIC iterations, D, E and the output register.
// Throughput: one item per cycle while the skid buffer is empty; the 28-stage CORDIC pipeline sets the depth.
// A one-entry skid buffer behind the output register absorbs a stall;
// o_stall rises only while that buffer is occupied.
// Reset (synchronous, active low) empties the pipeline and sets bucket_count 8,
// magnitude_threshold 0.
module gradient_orientation_binning (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Config write port
    input  logic                                 i_cfg_we,
    input  logic [gob_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gob_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [gob_pkg::GRAD_W-1:0]    i_grad_x,
    input  logic signed [gob_pkg::GRAD_W-1:0]    i_grad_y,
    // Output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [gob_pkg::MAG_W-1:0]            o_magnitude,
    output logic [gob_pkg::BKT_W-1:0]            o_bucket_even,
    output logic [gob_pkg::BKT_W-1:0]            o_bucket_shifted
);

    localparam int GW   = gob_pkg::GRAD_W;
    localparam int CXW  = gob_pkg::CX_W;
    localparam int ZW   = gob_pkg::Z_W;
    localparam int NST  = gob_pkg::CORDIC_STEPS;
    localparam int FS   = gob_pkg::FRAC_SHIFT;
    localparam int MW   = gob_pkg::MAG_W;
    localparam int BW   = gob_pkg::BKT_W;
    localparam int SW   = gob_pkg::SECTOR_W;
    localparam int TW   = gob_pkg::TURN_W;
    localparam int QW   = gob_pkg::Q_W;
    localparam int OW   = gob_pkg::OCT_W;

    // ------------------------------------------------------------------
    // Config registers
    logic [gob_pkg::CNT_W-1:0] r_bucket_count;
    logic [gob_pkg::THR_W-1:0] r_mag_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= gob_pkg::BUCKET_COUNT_RST;
            r_mag_thr      <= gob_pkg::MAG_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gob_pkg::CFG_BUCKET_COUNT:  r_bucket_count <= i_cfg_data[gob_pkg::CNT_W-1:0];
                gob_pkg::CFG_MAG_THRESHOLD: r_mag_thr      <= i_cfg_data[gob_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves whenever the skid buffer is empty
    logic r_skid_v;
    logic en;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    // ------------------------------------------------------------------
    // Stage A: input register
    logic                 r_a_v;
    logic signed [GW-1:0] r_a_gx, r_a_gy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_gx <= i_grad_x;
            r_a_gy <= i_grad_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage B logic: magnitude, edge test, quarter-turn fold, octant choice
    logic signed [GW:0]   gx_ext, gy_ext, u, v;
    logic        [GW-1:0] ax, ay;
    logic        [GW-2:0] mag_sum;
    logic                 b_edge;
    logic        [MW-1:0] b_mag;
    logic signed [GW:0]   ru, rv;
    logic        [1:0]    b_quad;
    logic        [GW-1:0] ru_u, rv_u, b_x0, b_y0;
    gob_pkg::t_oct_case   b_case;

    assign gx_ext = {r_a_gx[GW-1], r_a_gx};
    assign gy_ext = {r_a_gy[GW-1], r_a_gy};
    assign u      = -gx_ext;
    assign v      = -gy_ext;

    always_comb begin
        ax = r_a_gx[GW-1] ? u[GW-1:0] : gx_ext[GW-1:0];
        ay = r_a_gy[GW-1] ? v[GW-1:0] : gy_ext[GW-1:0];
        mag_sum = {1'b0, ax[GW-1:2]} + {1'b0, ay[GW-1:2]};
        b_edge  = mag_sum > {1'b0, r_mag_thr};
        b_mag   = (mag_sum > (GW-1)'(255)) ? {MW{1'b1}} : mag_sum[MW-1:0];
    end

    // Rotate (-gx, -gy) by quarter turns into x > 0, y >= 0
    always_comb begin
        if (u > 0 && v >= 0) begin
            b_quad = 2'd0; ru = u;  rv = v;
        end else if (v > 0 && u <= 0) begin
            b_quad = 2'd1; ru = v;  rv = -u;
        end else if (u < 0 && v <= 0) begin
            b_quad = 2'd2; ru = -u; rv = -v;
        end else if (v < 0 && u >= 0) begin
            b_quad = 2'd3; ru = -v; rv = u;
        end else begin
            b_quad = 2'd0; ru = '0; rv = '0;
        end
        ru_u = ru[GW-1:0];
        rv_u = rv[GW-1:0];
        if (rv_u == '0) begin
            b_case = gob_pkg::OCT_ZERO;
        end else if (rv_u == ru_u) begin
            b_case = gob_pkg::OCT_DIAG;
        end else if (rv_u < ru_u) begin
            b_case = gob_pkg::OCT_LOW;
        end else begin
            b_case = gob_pkg::OCT_HIGH;
        end
        b_x0 = (b_case == gob_pkg::OCT_HIGH) ? rv_u : ru_u;
        b_y0 = (b_case == gob_pkg::OCT_HIGH) ? ru_u : rv_u;
    end

    // ------------------------------------------------------------------
    // CORDIC pipeline: index 0 is stage B, index NST the last iteration
    logic                  r_c_v    [0:NST];
    logic                  r_c_edge [0:NST];
    logic [MW-1:0]         r_c_mag  [0:NST];
    logic [1:0]            r_c_quad [0:NST];
    gob_pkg::t_oct_case    r_c_case [0:NST];
    logic signed [CXW-1:0] r_cx     [0:NST];
    logic signed [CXW-1:0] r_cy     [0:NST];
    logic signed [ZW-1:0]  r_z      [0:NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v[0] <= 1'b0;
        end else if (en) begin
            r_c_v[0] <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_edge[0] <= b_edge;
            r_c_mag[0]  <= b_mag;
            r_c_quad[0] <= b_quad;
            r_c_case[0] <= b_case;
            r_cx[0]     <= $signed({{(CXW-GW-FS){1'b0}}, b_x0, {FS{1'b0}}});
            r_cy[0]     <= $signed({{(CXW-GW-FS){1'b0}}, b_y0, {FS{1'b0}}});
            r_z[0]      <= '0;
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_cordic
        localparam logic [CXW-1:0] LOW_MASK = (CXW'(1) << i) - CXW'(1);
        localparam logic signed [ZW-1:0] ANG = $signed(ZW'(gob_pkg::ATAN_LUT[i]));

        logic signed [CXW-1:0] dx, dy;
        logic                  corr;

        // x stays positive, so the shift equals truncation; y rounds toward zero
        assign dx   = r_cx[i] >>> i;
        assign corr = r_cy[i][CXW-1] && (|(r_cy[i] & LOW_MASK));
        assign dy   = (r_cy[i] >>> i) + $signed({{(CXW-1){1'b0}}, corr});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_v[i+1] <= 1'b0;
            end else if (en) begin
                r_c_v[i+1] <= r_c_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c_edge[i+1] <= r_c_edge[i];
                r_c_mag[i+1]  <= r_c_mag[i];
                r_c_quad[i+1] <= r_c_quad[i];
                r_c_case[i+1] <= r_c_case[i];
                if (!r_cy[i][CXW-1]) begin
                    r_cx[i+1] <= r_cx[i] + dy;
                    r_cy[i+1] <= r_cy[i] - dx;
                    r_z[i+1]  <= r_z[i] + ANG;
                end else begin
                    r_cx[i+1] <= r_cx[i] - dy;
                    r_cy[i+1] <= r_cy[i] + dx;
                    r_z[i+1]  <= r_z[i] - ANG;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D: clamp octant angle, unfold, wrap, keep 16-bit turn fraction
    logic [OW-1:0] zc;
    logic [QW-1:0] q_ang;
    logic [ZW-1:0] z_tot, z_wrap;

    always_comb begin
        if (r_z[NST][ZW-1]) begin
            zc = '0;
        end else if (|r_z[NST][ZW-2:OW]) begin
            zc = {OW{1'b1}};
        end else begin
            zc = r_z[NST][OW-1:0];
        end
        case (r_c_case[NST])
            gob_pkg::OCT_ZERO: q_ang = '0;
            gob_pkg::OCT_DIAG: q_ang = gob_pkg::ANGLE_EIGHTH;
            gob_pkg::OCT_LOW:  q_ang = {{(QW-OW){1'b0}}, zc};
            gob_pkg::OCT_HIGH: q_ang = gob_pkg::ANGLE_QUARTER - {{(QW-OW){1'b0}}, zc};
            default:           q_ang = '0;
        endcase
        z_tot  = {1'b0, r_c_quad[NST], {(ZW-3){1'b0}}} + {{(ZW-QW){1'b0}}, q_ang};
        z_wrap = (z_tot >= gob_pkg::ANGLE_ONE_TURN) ? (z_tot - gob_pkg::ANGLE_ONE_TURN)
                                                    : z_tot;
    end

    logic          r_d_v, r_d_edge;
    logic [MW-1:0] r_d_mag;
    logic [TW-1:0] r_d_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_edge <= r_c_edge[NST];
            r_d_mag  <= r_c_mag[NST];
            r_d_turn <= z_wrap[gob_pkg::TURN_LSB+TW-1:gob_pkg::TURN_LSB];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: sector = (turn * 2N) >> 16
    logic [gob_pkg::CNT_W-1:0] n_clamped;
    logic [SW-1:0]             two_n;
    logic [TW+SW-1:0]          prod;
    logic [SW-1:0]             sector;

    always_comb begin
        if (r_bucket_count == '0) begin
            n_clamped = gob_pkg::CNT_W'(1);
        end else if (r_bucket_count > gob_pkg::BUCKET_COUNT_MAX) begin
            n_clamped = gob_pkg::BUCKET_COUNT_MAX;
        end else begin
            n_clamped = r_bucket_count;
        end
        two_n  = {n_clamped, 1'b0};
        prod   = (TW+SW)'(r_d_turn) * (TW+SW)'(two_n);
        sector = (prod[TW+SW-1:TW] >= two_n) ? '0 : prod[TW+SW-1:TW];
    end

    logic          r_e_v, r_e_edge;
    logic [MW-1:0] r_e_mag;
    logic [SW-1:0] r_e_sector;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_edge   <= r_d_edge;
            r_e_mag    <= r_d_mag;
            r_e_sector <= sector;
        end
    end

    // ------------------------------------------------------------------
    // Bucket split and edge gating
    logic [SW-1:0] sector_next;
    logic [MW-1:0] res_mag;
    logic [BW-1:0] res_even, res_shift;

    always_comb begin
        sector_next = r_e_sector + SW'(1);
        if (sector_next == two_n) begin
            sector_next = '0;
        end
        res_mag   = r_e_edge ? r_e_mag : '0;
        res_even  = r_e_edge ? r_e_sector[BW:1] : '0;
        res_shift = r_e_edge ? sector_next[BW:1] : '0;
    end

    // ------------------------------------------------------------------
    // Output register with one-entry skid buffer
    logic          r_out_v;
    logic [MW-1:0] r_out_mag, r_skid_mag;
    logic [BW-1:0] r_out_even, r_skid_even;
    logic [BW-1:0] r_out_shift, r_skid_shift;
    logic          p_take, out_free;

    assign p_take   = en && r_e_v;
    assign out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= p_take;
            end
        end else if (p_take) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out_mag   <= r_skid_mag;
                r_out_even  <= r_skid_even;
                r_out_shift <= r_skid_shift;
            end else if (p_take) begin
                r_out_mag   <= res_mag;
                r_out_even  <= res_even;
                r_out_shift <= res_shift;
            end
        end else if (p_take) begin
            r_skid_mag   <= res_mag;
            r_skid_even  <= res_even;
            r_skid_shift <= res_shift;
        end
    end

    assign o_valid          = r_out_v;
    assign o_magnitude      = r_out_mag;
    assign o_bucket_even    = r_out_even;
    assign o_bucket_shifted = r_out_shift;

endmodule
